>>> rtl/taylor_series_evaluator_unit_macros.svh
`ifndef TAYLOR_SERIES_EVALUATOR_UNIT_MACROS_SVH
`define TAYLOR_SERIES_EVALUATOR_UNIT_MACROS_SVH

// Checks an implication within the same clock cycle.
`define TSEU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks an implication in the following clock cycle.
`define TSEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tse_pkg.sv
`default_nettype none

package tse_pkg;

    localparam int SUM_W  = 48;
    localparam int MAG_W  = 47;
    localparam int X_W    = 32;
    localparam int FUNC_W = 3;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] TERM_COUNT_RST = 6'd8;

    localparam logic [FUNC_W-1:0] FUNC_EXP  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIN  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COS  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LN   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ATAN = 3'd4;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = SUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_ACCUM,
        ACT_MUL_LO,
        ACT_MUL_HI,
        ACT_MUL_FIX,
        ACT_DIV_LOAD,
        ACT_DIV_STEP,
        ACT_DIV_WB,
        ACT_WRITE_OUT
    } act_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SKIP,
        COND_LAST,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_CHECK,
        STEP_ACCUM,
        STEP_MUL_LO,
        STEP_MUL_HI,
        STEP_MUL_FIX,
        STEP_DIV_LOAD,
        STEP_DIV_STEP,
        STEP_DIV_WB,
        STEP_FINISH
    } step_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t taken;
        step_t other;
    } ctrl_word_t;

    typedef struct packed {
        logic no_input;
        logic skip;
        logic last;
        logic div_busy;
        logic out_busy;
    } cond_flags_t;

endpackage

`default_nettype wire

>>> rtl/tse_sequencer.sv
`default_nettype none

module tse_sequencer
    import tse_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  cond_flags_t flags,
    output ctrl_word_t  ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  cond_true;

    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        case (s)
            STEP_IDLE:     w = '{ACT_LOAD,      COND_NO_INPUT, STEP_IDLE,     STEP_CHECK};
            STEP_CHECK:    w = '{ACT_NOP,       COND_SKIP,     STEP_FINISH,   STEP_ACCUM};
            STEP_ACCUM:    w = '{ACT_ACCUM,     COND_LAST,     STEP_FINISH,   STEP_MUL_LO};
            STEP_MUL_LO:   w = '{ACT_MUL_LO,    COND_ALWAYS,   STEP_MUL_HI,   STEP_MUL_HI};
            STEP_MUL_HI:   w = '{ACT_MUL_HI,    COND_ALWAYS,   STEP_MUL_FIX,  STEP_MUL_FIX};
            STEP_MUL_FIX:  w = '{ACT_MUL_FIX,   COND_ALWAYS,   STEP_DIV_LOAD, STEP_DIV_LOAD};
            STEP_DIV_LOAD: w = '{ACT_DIV_LOAD,  COND_ALWAYS,   STEP_DIV_STEP, STEP_DIV_STEP};
            STEP_DIV_STEP: w = '{ACT_DIV_STEP,  COND_DIV_BUSY, STEP_DIV_STEP, STEP_DIV_WB};
            STEP_DIV_WB:   w = '{ACT_DIV_WB,    COND_ALWAYS,   STEP_ACCUM,    STEP_ACCUM};
            STEP_FINISH:   w = '{ACT_WRITE_OUT, COND_OUT_BUSY, STEP_FINISH,   STEP_IDLE};
            default:       w = '{ACT_NOP,       COND_ALWAYS,   STEP_IDLE,     STEP_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = ucode(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_INPUT: cond_true = flags.no_input;
            COND_SKIP:     cond_true = flags.skip;
            COND_LAST:     cond_true = flags.last;
            COND_DIV_BUSY: cond_true = flags.div_busy;
            COND_OUT_BUSY: cond_true = flags.out_busy;
            default:       cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctrl.taken : ctrl.other;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tse_divider.sv
`default_nettype none

module tse_divider
    import tse_pkg::*;
#(
    parameter int DEN_W = 6
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire              step,
    input  wire  [SUM_W-1:0] num,
    input  wire  [DEN_W-1:0] den,
    output logic [SUM_W-1:0] quot,
    output logic             more_steps
);

    logic [SUM_W-1:0]     num_reg;
    logic [SUM_W-1:0]     num_next;
    logic [DEN_W:0]       rem_reg;
    logic [DEN_W:0]       rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [SUM_W-1:0]     q_work;
    logic [DEN_W:0]       r_work;

    // Restoring division, several quotient bits per cycle; the divisor is narrow.
    always_comb begin
        r_work = rem_reg;
        q_work = num_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            r_work = {r_work[DEN_W-1:0], q_work[SUM_W-1]};
            q_work = {q_work[SUM_W-2:0], 1'b0};
            if (r_work >= {1'b0, den}) begin
                r_work    = r_work - {1'b0, den};
                q_work[0] = 1'b1;
            end
        end
    end

    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            num_next = num;
            rem_next = '0;
            cnt_next = '0;
        end else if (step) begin
            num_next = q_work;
            rem_next = r_work;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign quot       = num_reg;
    assign more_steps = (cnt_reg != DIV_CNT_W'(DIV_CYCLES - 1));

endmodule

`default_nettype wire

>>> rtl/taylor_series_evaluator_unit.sv
// Truncated Maclaurin series evaluator for e^x, sin, cos, ln(1+x) and arctan.
// The input channel (s_valid/s_ready) carries an opcode and a 32-bit signed
// argument; the result channel (m_valid/m_ready) returns one saturated 48-bit
// sum with a domain error and an overflow flag for every input transfer.
// A microcoded sequencer steps a datapath with one shared 32x32 multiplier and
// an iterative divider that produces eight quotient bits per cycle.
// Each term after the first takes two partial products, a rounding step, a
// divider load, six divider steps, a write-back and the accumulation.
// The series steps through term_count terms for exp, sin, cos and arctan and
// one more for ln; a domain error or a term count of zero goes straight from
// the check step to the result.
// One item is worked on at a time; the next input transfer is taken once the
// result has moved into the output register, even while that result waits.
// A stalled receiver holds the result and stops the sequencer before it
// writes the following one. Synchronous reset sets term_count to 8, empties
// the output register and returns the sequencer to its idle step. The user
// must write term_count through cfg_we and cfg_wdata only while the block is
// idle, which it does not enforce; values above MAX_TERMS count as MAX_TERMS.
`default_nettype none
`include "taylor_series_evaluator_unit_macros.svh"

module taylor_series_evaluator_unit
    import tse_pkg::*;
#(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 24
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_we,
    input  wire        [CNT_W-1:0]  cfg_wdata,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire        [FUNC_W-1:0] s_func_select,
    input  wire signed [X_W-1:0]    s_x_value,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic signed [SUM_W-1:0] m_series_sum,
    output logic                    m_domain_error,
    output logic                    m_overflow
);

    localparam int N_W   = $clog2(MAX_TERMS + 1);
    localparam int SHIFT = X_W - FRAC_BITS;
    localparam logic [X_W-1:0]     ONE_X    = X_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0]   ONE_MAG  = MAG_W'(1) << FRAC_BITS;
    localparam logic [2*X_W-1:0]   HALF     = (2*X_W)'(1) << (FRAC_BITS - 1);
    localparam logic [2*X_W-1:0]   HI_LIMIT = (2*X_W)'(MAG_MAX) >> SHIFT;

    ctrl_word_t  ctrl;
    cond_flags_t flags;

    logic [CNT_W-1:0]  term_count_reg;
    logic [FUNC_W-1:0] op_reg, op_next;
    logic              xneg_reg, xneg_next;
    logic [X_W-1:0]    xmag_reg, xmag_next;
    logic              derr_reg, derr_next;
    logic              skip_reg, skip_next;
    logic [N_W-1:0]    last_reg, last_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [MAG_W-1:0]  p_reg, p_next;
    logic [MAG_W-1:0]  term_reg, term_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [2*X_W-1:0]  prod_lo_reg, prod_lo_next;
    logic [2*X_W-1:0]  prod_hi_reg, prod_hi_next;

    logic              m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]  m_sum_reg, m_sum_next;
    logic              m_derr_reg, m_derr_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              in_neg;
    logic [X_W-1:0]    in_mag;
    logic              in_derr;
    logic [N_W-1:0]    in_count;
    logic              accept;

    logic [X_W-1:0]    mul_a;
    logic [2*X_W-1:0]  mul_prod;

    logic [2*X_W:0]    low_sum;
    logic [2*X_W-1:0]  low_part;
    logic [2*X_W-1:0]  fix_wide;
    logic              fix_ovf;
    logic [MAG_W-1:0]  fix_mag;

    logic [1:0]        quad;
    logic              pneg;
    logic              add_en;
    logic              add_neg;
    logic [SUM_W:0]    add_wide;
    logic              add_ovf;
    logic [SUM_W-1:0]  add_sum;

    logic              div_start;
    logic              div_step;
    logic [SUM_W-1:0]  div_num;
    logic [SUM_W-1:0]  div_quot;
    logic              div_more;

    logic              out_busy;
    logic              out_write;

    tse_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tse_divider #(
        .DEN_W (N_W)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .step       (div_step),
        .num        (div_num),
        .den        (n_reg),
        .quot       (div_quot),
        .more_steps (div_more)
    );

    assign s_ready   = aresetn && (ctrl.act == ACT_LOAD);
    assign accept    = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;
    assign out_write = (ctrl.act == ACT_WRITE_OUT) && !out_busy;

    assign flags.no_input = !s_valid;
    assign flags.skip     = skip_reg;
    assign flags.last     = (n_reg == last_reg);
    assign flags.div_busy = div_more;
    assign flags.out_busy = out_busy;

    assign div_start = (ctrl.act == ACT_DIV_LOAD);
    assign div_step  = (ctrl.act == ACT_DIV_STEP);
    assign div_num   = {1'b0, p_reg} + SUM_W'(n_reg >> 1);

    // Argument decode, domain check and term count limit at the input transfer.
    always_comb begin
        in_neg = s_x_value[X_W-1];
        in_mag = in_neg ? (~unsigned'(s_x_value) + 1'b1) : unsigned'(s_x_value);
        case (s_func_select)
            FUNC_EXP:  in_derr = 1'b0;
            FUNC_SIN:  in_derr = 1'b0;
            FUNC_COS:  in_derr = 1'b0;
            FUNC_LN:   in_derr = (in_neg && (in_mag >= ONE_X)) || (!in_neg && (in_mag > ONE_X));
            FUNC_ATAN: in_derr = (in_mag > ONE_X);
            default:   in_derr = 1'b1;
        endcase
        if (int'(term_count_reg) > MAX_TERMS) begin
            in_count = N_W'(MAX_TERMS);
        end else begin
            in_count = N_W'(term_count_reg);
        end
    end

    assign mul_a    = (ctrl.act == ACT_MUL_LO) ? p_reg[X_W-1:0]
                                               : X_W'(p_reg[MAG_W-1:X_W]);
    assign mul_prod = (2*X_W)'(mul_a) * (2*X_W)'(xmag_reg);

    // Rounds the two partial products back to the magnitude format, saturating on overflow.
    always_comb begin
        low_sum  = {1'b0, prod_lo_reg} + {1'b0, HALF};
        low_part = (2*X_W)'(low_sum >> FRAC_BITS);
        fix_wide = (prod_hi_reg << SHIFT) + low_part;
        fix_ovf  = (prod_hi_reg > HI_LIMIT) || (fix_wide > (2*X_W)'(MAG_MAX));
        fix_mag  = fix_ovf ? MAG_MAX : fix_wide[MAG_W-1:0];
    end

    // Which terms are summed and with which sign, and the saturating addition.
    always_comb begin
        quad = 2'(n_reg);
        pneg = xneg_reg && n_reg[0];
        case (op_reg)
            FUNC_EXP: begin
                add_en  = 1'b1;
                add_neg = pneg;
            end
            FUNC_SIN: begin
                add_en  = quad[0];
                add_neg = pneg ^ (quad == 2'd3);
            end
            FUNC_COS: begin
                add_en  = !quad[0];
                add_neg = pneg ^ (quad == 2'd2);
            end
            FUNC_LN: begin
                add_en  = (n_reg != '0);
                add_neg = pneg ^ !n_reg[0];
            end
            FUNC_ATAN: begin
                add_en  = quad[0];
                add_neg = pneg ^ (quad == 2'd3);
            end
            default: begin
                add_en  = 1'b0;
                add_neg = 1'b0;
            end
        endcase
        add_wide = add_neg ? ({sum_reg[SUM_W-1], sum_reg} - {2'b00, term_reg})
                           : ({sum_reg[SUM_W-1], sum_reg} + {2'b00, term_reg});
        add_ovf  = (add_wide[SUM_W] != add_wide[SUM_W-1]);
        add_sum  = add_ovf ? (add_wide[SUM_W] ? SUM_MIN : SUM_MAX) : add_wide[SUM_W-1:0];
    end

    always_comb begin
        op_next      = op_reg;
        xneg_next    = xneg_reg;
        xmag_next    = xmag_reg;
        derr_next    = derr_reg;
        skip_next    = skip_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        case (ctrl.act)
            ACT_LOAD: begin
                if (s_valid) begin
                    op_next   = s_func_select;
                    xneg_next = in_neg;
                    xmag_next = in_mag;
                    derr_next = in_derr;
                    skip_next = in_derr || (in_count == '0);
                    last_next = (s_func_select == FUNC_LN) ? in_count : in_count - 1'b1;
                    n_next    = '0;
                    p_next    = ONE_MAG;
                    term_next = ONE_MAG;
                    sum_next  = '0;
                    ovf_next  = 1'b0;
                end
            end
            ACT_ACCUM: begin
                if (add_en) begin
                    sum_next = add_sum;
                    ovf_next = ovf_reg || add_ovf;
                end
                if (n_reg != last_reg) begin
                    n_next = n_reg + 1'b1;
                end
            end
            ACT_MUL_LO: begin
                prod_lo_next = mul_prod;
            end
            ACT_MUL_HI: begin
                prod_hi_next = mul_prod;
            end
            ACT_MUL_FIX: begin
                p_next   = fix_mag;
                ovf_next = ovf_reg || fix_ovf;
            end
            ACT_DIV_WB: begin
                term_next = div_quot[MAG_W-1:0];
                if ((op_reg == FUNC_EXP) || (op_reg == FUNC_SIN) || (op_reg == FUNC_COS)) begin
                    p_next = div_quot[MAG_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        m_derr_next  = m_derr_reg;
        m_ovf_next   = m_ovf_reg;
        if (out_write) begin
            m_valid_next = 1'b1;
            m_sum_next   = derr_reg ? '0 : sum_reg;
            m_derr_next  = derr_reg;
            m_ovf_next   = !derr_reg && ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= TERM_COUNT_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                term_count_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        xneg_reg    <= xneg_next;
        xmag_reg    <= xmag_next;
        derr_reg    <= derr_next;
        skip_reg    <= skip_next;
        last_reg    <= last_next;
        n_reg       <= n_next;
        p_reg       <= p_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        ovf_reg     <= ovf_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        m_sum_reg   <= m_sum_next;
        m_derr_reg  <= m_derr_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_series_sum   = signed'(m_sum_reg);
    assign m_domain_error = m_derr_reg;
    assign m_overflow     = m_ovf_reg;

    `TSEU_ASSERT_NEXT(a_accept_leaves_idle, accept, !s_ready, "input taken twice in a row")
    `TSEU_ASSERT_NEXT(a_write_shows_result, out_write, m_valid, "written result not offered")
    `TSEU_ASSERT_SAME(a_domain_error_clean, m_valid && m_domain_error,
        (m_series_sum == '0) && !m_overflow, "domain error with non-zero result")

endmodule

`default_nettype wire
